>>> hdl/prd_pkg.sv
`default_nettype none
package prd_pkg;

   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned HalfWidth   = 16;
   localparam int unsigned PosWidth    = 3;
   localparam int unsigned PhaseWidth  = 3;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 40;

   // parser phases
   localparam logic [PhaseWidth-1:0] PH_HEADER = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_COUNT  = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_DATA   = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_IDLE   = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_EMIT   = 3'd4;

   // header byte positions that matter
   localparam logic [PosWidth-1:0] POS_ROWS_HI = 3'd6;
   localparam logic [PosWidth-1:0] POS_ROWS_LO = 3'd7;

   localparam logic [HalfWidth-1:0] COLUMN_MAX = 16'hffff;

   typedef struct packed {
      logic [HalfWidth-1:0]   column;
      logic [HalfWidth-1:0]   row;
      logic [NibbleWidth-1:0] level;
      logic                   last;
   } pixel_type;

endpackage
`default_nettype wire

>>> hdl/prd_out_reg.sv
`default_nettype none
module prd_out_reg (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  wire prd_pkg::pixel_type pixel_in,
   output logic                    slot_free,
   input  wire                     out_ready,
   output logic                    out_valid,
   output prd_pkg::pixel_type      pixel_out
);
   import prd_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   pixel_type pixel_ff;

   // slot opens when empty or when the held item is taken this cycle
   assign slot_free = !valid_ff || out_ready;
   assign valid_in  = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign pixel_out = pixel_ff;

endmodule
`default_nettype wire

>>> hdl/precip_rle_packet_decoder.sv
`default_nettype none
// A data byte's first pixel passes the run and phase registers, then the
// output register, before it is valid. A data byte with run length R holds
// the input while it is expanded one pixel per cycle from the single column
// incrementer, while rsp_tready does not stall the output, then a wrap-up
// step closes the byte; header and count bytes are taken every cycle.
// Reset: synchronous, active high; returns to the header phase, output empty.
module precip_rle_packet_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] pixel_column, [31:16] pixel_row,
                                    // [35:32] level, [39:36] zero
   output logic        rsp_tlast    // last_of_run
);
   import prd_pkg::*;

   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [7:0]             hi_ff, hi_in;
   logic [HalfWidth-1:0]   rows_left_ff, rows_left_in;
   logic [HalfWidth-1:0]   row_ff, row_in;
   logic [HalfWidth-1:0]   bytes_left_ff, bytes_left_in;
   logic [HalfWidth-1:0]   column_ff, column_in;
   logic [NibbleWidth-1:0] run_ff, run_in;
   logic [NibbleWidth-1:0] level_ff, level_in;

   logic      accept;
   logic      slot_free;
   logic      load;
   logic [HalfWidth-1:0] halfword;
   logic [HalfWidth-1:0] column_next;
   pixel_type pixel_new;
   pixel_type pixel_q;

   // Input is held off while a byte's run is being expanded.
   assign req_tready = (phase_ff != PH_EMIT);
   assign accept     = req_tvalid && req_tready;
   assign halfword   = {hi_ff, req_tdata};

   // Column step: saturating increment.
   assign column_next = (column_ff == COLUMN_MAX) ? column_ff
                                                  : column_ff + HalfWidth'(1);

   // Emit one pixel per cycle while run steps remain and the output slot opens.
   assign load = (phase_ff == PH_EMIT) && (run_ff != '0) && slot_free;

   always_comb begin
      pixel_new.column = column_ff;
      pixel_new.row    = row_ff;
      pixel_new.level  = level_ff;
      pixel_new.last   = (run_ff == NibbleWidth'(1));
   end

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      hi_in         = hi_ff;
      rows_left_in  = rows_left_ff;
      row_in        = row_ff;
      bytes_left_in = bytes_left_ff;
      column_in     = column_ff;
      run_in        = run_ff;
      level_in      = level_ff;

      unique case (phase_ff) inside
         PH_HEADER, PH_IDLE: begin
            if (accept) begin
               // idle restarts the header at byte 0
               if (phase_ff == PH_IDLE || pos_ff == '0) begin
                  pos_in   = PosWidth'(1);
                  phase_in = PH_HEADER;
               end else if (pos_ff == POS_ROWS_LO) begin
                  rows_left_in = halfword;
                  row_in       = '0;
                  column_in    = '0;
                  pos_in       = '0;
                  phase_in     = (halfword == '0) ? PH_IDLE : PH_COUNT;
               end else begin
                  if (pos_ff == POS_ROWS_HI) begin
                     hi_in = req_tdata;
                  end
                  pos_in = pos_ff + PosWidth'(1);
               end
            end
         end
         PH_COUNT: begin
            if (accept) begin
               if (!pos_ff[0]) begin
                  hi_in  = req_tdata;
                  pos_in = PosWidth'(1);
               end else begin
                  bytes_left_in = halfword;
                  pos_in        = '0;
                  column_in     = '0;
                  if (halfword == '0) begin
                     // empty row: finish it at once
                     rows_left_in = rows_left_ff - HalfWidth'(1);
                     row_in       = row_ff + HalfWidth'(1);
                     phase_in     = (rows_left_ff == HalfWidth'(1)) ? PH_IDLE : PH_COUNT;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            if (accept) begin
               run_in   = req_tdata[7:4];
               level_in = req_tdata[3:0];
               phase_in = PH_EMIT;
            end
         end
         PH_EMIT: begin
            if (run_ff == '0) begin
               // run done: count the byte off and close the row if needed
               bytes_left_in = bytes_left_ff - HalfWidth'(1);
               if (bytes_left_ff == HalfWidth'(1)) begin
                  rows_left_in = rows_left_ff - HalfWidth'(1);
                  row_in       = row_ff + HalfWidth'(1);
                  column_in    = '0;
                  pos_in       = '0;
                  phase_in     = (rows_left_ff == HalfWidth'(1)) ? PH_IDLE : PH_COUNT;
               end else begin
                  phase_in = PH_DATA;
               end
            end else if (load) begin
               column_in = column_next;
               run_in    = run_ff - NibbleWidth'(1);
            end
         end
         default: begin
            phase_in = PH_HEADER;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         hi_ff         <= '0;
         rows_left_ff  <= '0;
         row_ff        <= '0;
         bytes_left_ff <= '0;
         column_ff     <= '0;
         run_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         hi_ff         <= hi_in;
         rows_left_ff  <= rows_left_in;
         row_ff        <= row_in;
         bytes_left_ff <= bytes_left_in;
         column_ff     <= column_in;
         run_ff        <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   // Output register: lets the next byte in while the last pixel waits.
   prd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .pixel_in  (pixel_new),
      .slot_free (slot_free),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .pixel_out (pixel_q)
   );

   assign rsp_tdata = {4'b0000, pixel_q.level, pixel_q.row, pixel_q.column};
   assign rsp_tlast = pixel_q.last;

endmodule
`default_nettype wire
